// ===== rtl/core/blfm_pkg.sv =====
// ---------------------------------------------------------------------------
// Battery level filter and monitor package
// Shared types, register codes, reset values and stage records.
// ---------------------------------------------------------------------------
package blfm_pkg;

  localparam int unsigned LEVEL_W        = 16;
  localparam int unsigned ALPHA_W        = 9;
  localparam int unsigned COUNT_W        = 4;
  localparam int unsigned CFG_IDX_W      = 3;
  localparam int unsigned CFG_DATA_W     = 16;

  localparam int unsigned RING_DEPTH_DEF = 8;
  localparam int unsigned ADC_BITS_DEF   = 12;
  localparam int unsigned FRAC_BITS_DEF  = 4;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE = 9'd256;
  localparam logic [COUNT_W-1:0] RUN_MAX   = 4'd15;
  localparam logic [LEVEL_W-1:0] HOLD_MAX  = 16'hFFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SENSE_PRESENT = 3'd0,
    CFG_GLITCH_STEP   = 3'd1,
    CFG_SMOOTH_ALPHA  = 3'd2,
    CFG_LOW_THRESHOLD = 3'd3,
    CFG_VALID_FLOOR   = 3'd4,
    CFG_ABSENT_LEVEL  = 3'd5,
    CFG_CONFIRM_COUNT = 3'd6,
    CFG_HOLDOFF_ITEMS = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic                 sense_present;
    logic [LEVEL_W-1:0]   glitch_step;
    logic [ALPHA_W-1:0]   smooth_alpha;
    logic [LEVEL_W-1:0]   low_threshold;
    logic [LEVEL_W-1:0]   valid_floor;
    logic [LEVEL_W-1:0]   absent_level;
    logic [COUNT_W-1:0]   confirm_count;
    logic [LEVEL_W-1:0]   holdoff_items;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    sense_present: 1'b1,
    glitch_step:   16'd320,
    smooth_alpha:  9'd64,
    low_threshold: 16'd36000,
    valid_floor:   16'd32000,
    absent_level:  16'd44000,
    confirm_count: 4'd5,
    holdoff_items: 16'd100
  };

  typedef enum logic [1:0] {
    LED_OFF   = 2'd0,
    LED_ON    = 2'd1,
    LED_BLINK = 2'd2
  } led_e;

  typedef enum logic [1:0] {
    FM_PRIME  = 2'd0,
    FM_KEEP   = 2'd1,
    FM_UPDATE = 2'd2
  } fmode_e;

  typedef struct packed {
    fmode_e mode;
    logic   link_up;
  } stage_ctrl_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] filtered_level;
    logic               low_latched;
    led_e               led_mode;
  } result_t;

endpackage

// ===== rtl/core/blfm_in_if.sv =====
// ---------------------------------------------------------------------------
// Sample input channel
// Carries one converter sample and the link flag per word.
// ---------------------------------------------------------------------------
interface blfm_in_if #(
  parameter int unsigned ADC_BITS = blfm_pkg::ADC_BITS_DEF
);
  logic                valid;
  logic                ready;
  logic [ADC_BITS-1:0] adc_code;
  logic                link_up;

  modport source (output valid, output adc_code, output link_up, input ready);
  modport sink   (input valid, input adc_code, input link_up, output ready);
endinterface

// ===== rtl/core/blfm_out_if.sv =====
// ---------------------------------------------------------------------------
// Result output channel
// Carries the smoothed level, the low battery flag and the LED mode.
// ---------------------------------------------------------------------------
interface blfm_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] filtered_level;
  logic        low_latched;
  logic [1:0]  led_mode;

  modport source (output valid, output filtered_level, output low_latched,
                  output led_mode, input ready);
  modport sink   (input valid, input filtered_level, input low_latched,
                  input led_mode, output ready);
endinterface

// ===== rtl/core/blfm_filter.sv =====
// ---------------------------------------------------------------------------
// Slew limiter and ring sum stage
// Limits the sample against the last level, shifts it into the ring and
// keeps the running ring sum; the first word primes the whole ring.
// ---------------------------------------------------------------------------
module blfm_filter #(
  parameter  int unsigned RING_DEPTH = blfm_pkg::RING_DEPTH_DEF,
  parameter  int unsigned ADC_BITS   = blfm_pkg::ADC_BITS_DEF,
  parameter  int unsigned FRAC_BITS  = blfm_pkg::FRAC_BITS_DEF,
  localparam int unsigned SUM_W      = blfm_pkg::LEVEL_W + $clog2(RING_DEPTH)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  blfm_pkg::cfg_t        cfg_i,
  input  logic                  valid_i,
  input  logic [ADC_BITS-1:0]   adc_code_i,
  input  logic                  link_up_i,
  output logic                  ready_o,
  output logic                  valid_o,
  output blfm_pkg::stage_ctrl_t ctrl_o,
  output logic [SUM_W-1:0]      sum_o,
  input  logic                  ready_i
);

  localparam int unsigned LW  = blfm_pkg::LEVEL_W;
  localparam int unsigned EXT = ADC_BITS + LW;

  logic                  valid_q;
  logic                  primed_q, primed_d;
  logic [LW-1:0]         last_q, last_d;
  logic [LW-1:0]         ring_q [RING_DEPTH];
  logic [LW-1:0]         ring_d [RING_DEPTH];
  logic [SUM_W-1:0]      sum_q, sum_d;
  blfm_pkg::stage_ctrl_t ctrl_q, ctrl_d;

  logic [EXT-1:0] level_ext;
  logic [LW-1:0]  level;
  logic [LW-1:0]  prime_lvl;
  logic [LW-1:0]  lim;
  logic [LW:0]    up, rise, fall;
  logic [LW:0]    lim_up;
  logic           fire;

  assign ready_o = !valid_q || ready_i;
  assign fire    = valid_i && ready_o;

  assign level_ext = EXT'(adc_code_i) << FRAC_BITS;
  assign level     = level_ext[LW-1:0];
  assign prime_lvl = cfg_i.sense_present ? level : cfg_i.absent_level;

  assign up     = {cfg_i.glitch_step, 1'b0};
  assign rise   = {1'b0, level} - {1'b0, last_q};
  assign fall   = {1'b0, last_q} - {1'b0, level};
  assign lim_up = {1'b0, last_q} + up;

  always_comb begin
    if (level > last_q && rise > up) begin
      lim = lim_up[LW-1:0];
    end else if (level < last_q && fall > {1'b0, cfg_i.glitch_step}) begin
      lim = last_q - cfg_i.glitch_step;
    end else begin
      lim = level;
    end
  end

  always_comb begin
    ctrl_d.link_up = link_up_i;
    if (!primed_q) begin
      ctrl_d.mode = blfm_pkg::FM_PRIME;
    end else if (!cfg_i.sense_present) begin
      ctrl_d.mode = blfm_pkg::FM_KEEP;
    end else begin
      ctrl_d.mode = blfm_pkg::FM_UPDATE;
    end
  end

  always_comb begin
    primed_d = primed_q;
    last_d   = last_q;
    sum_d    = sum_q;
    for (int k = 0; k < RING_DEPTH; k++) begin
      ring_d[k] = ring_q[k];
    end
    if (fire) begin
      unique case (ctrl_d.mode)
        blfm_pkg::FM_PRIME: begin
          primed_d = 1'b1;
          last_d   = prime_lvl;
          sum_d    = SUM_W'(prime_lvl) * SUM_W'(RING_DEPTH);
          for (int k = 0; k < RING_DEPTH; k++) begin
            ring_d[k] = prime_lvl;
          end
        end
        blfm_pkg::FM_UPDATE: begin
          last_d    = lim;
          sum_d     = sum_q - SUM_W'(ring_q[RING_DEPTH-1]) + SUM_W'(lim);
          ring_d[0] = lim;
          for (int k = 1; k < RING_DEPTH; k++) begin
            ring_d[k] = ring_q[k-1];
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      primed_q <= 1'b0;
    end else begin
      primed_q <= primed_d;
      if (ready_o) begin
        valid_q <= valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    last_q <= last_d;
    sum_q  <= sum_d;
    ring_q <= ring_d;
    if (fire) begin
      ctrl_q <= ctrl_d;
    end
  end

  assign valid_o = valid_q;
  assign ctrl_o  = ctrl_q;
  assign sum_o   = sum_q;

`ifndef SYNTHESIS
  a_primed_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    primed_q |=> primed_q)
    else $error("ring lost its primed state");
`endif

endmodule

// ===== rtl/core/blfm_avg.sv =====
// ---------------------------------------------------------------------------
// Ring average stage
// Divides the ring sum by the ring depth through a reciprocal multiply.
// ---------------------------------------------------------------------------
module blfm_avg #(
  parameter  int unsigned RING_DEPTH = blfm_pkg::RING_DEPTH_DEF,
  localparam int unsigned SUM_W      = blfm_pkg::LEVEL_W + $clog2(RING_DEPTH)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  blfm_pkg::stage_ctrl_t ctrl_i,
  input  logic [SUM_W-1:0]      sum_i,
  output logic                  ready_o,
  output logic                  valid_o,
  output blfm_pkg::stage_ctrl_t ctrl_o,
  output logic [blfm_pkg::LEVEL_W-1:0] avg_o,
  input  logic                  ready_i
);

  localparam int unsigned LW    = blfm_pkg::LEVEL_W;
  localparam int unsigned SHIFT = SUM_W + $clog2(RING_DEPTH);
  localparam int unsigned MW    = SUM_W + 2;
  localparam int unsigned PW    = SUM_W + MW;
  localparam logic [MW-1:0] RECIP =
    MW'(((64'd1 << SHIFT) + 64'(RING_DEPTH) - 64'd1) / 64'(RING_DEPTH));

  logic                  valid_q;
  blfm_pkg::stage_ctrl_t ctrl_q;
  logic [LW-1:0]         avg_q;
  logic [PW-1:0]         prod;
  logic                  fire;

  assign ready_o = !valid_q || ready_i;
  assign fire    = valid_i && ready_o;
  assign prod    = PW'(sum_i) * PW'(RECIP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      ctrl_q <= ctrl_i;
      avg_q  <= prod[SHIFT +: LW];
    end
  end

  assign valid_o = valid_q;
  assign ctrl_o  = ctrl_q;
  assign avg_o   = avg_q;

endmodule

// ===== rtl/core/blfm_monitor.sv =====
// ---------------------------------------------------------------------------
// Smoother and low battery monitor stage
// Runs the exponential smoother, the holdoff counter and the low battery
// debounce, and holds the result word.
// ---------------------------------------------------------------------------
module blfm_monitor (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  blfm_pkg::cfg_t               cfg_i,
  input  logic                         valid_i,
  input  blfm_pkg::stage_ctrl_t        ctrl_i,
  input  logic [blfm_pkg::LEVEL_W-1:0] avg_i,
  output logic                         ready_o,
  output logic                         valid_o,
  output blfm_pkg::result_t            res_o,
  input  logic                         ready_i
);

  localparam int unsigned LW = blfm_pkg::LEVEL_W;
  localparam int unsigned CW = blfm_pkg::COUNT_W;
  localparam int unsigned PW = 28;

  logic                     valid_q;
  logic [LW-1:0]            smooth_q, smooth_d;
  logic [LW-1:0]            hold_q, hold_d;
  logic [CW-1:0]            run_q, run_d;
  logic                     low_q, low_d;
  blfm_pkg::result_t        res_q, res_d;

  logic [blfm_pkg::ALPHA_W-1:0] alpha;
  logic signed [LW+1:0]     diff;
  logic signed [PW-1:0]     diff_x, alpha_x, prod, rnd, step;
  logic [CW-1:0]            run_inc;
  logic                     in_hold;
  blfm_pkg::led_e           led_link;
  logic                     fire;

  assign ready_o = !valid_q || ready_i;
  assign fire    = valid_i && ready_o;

  assign alpha   = (cfg_i.smooth_alpha > blfm_pkg::ALPHA_ONE) ?
                   blfm_pkg::ALPHA_ONE : cfg_i.smooth_alpha;
  assign diff    = $signed({2'b00, avg_i}) - $signed({2'b00, smooth_q});
  assign diff_x  = {{(PW-LW-2){diff[LW+1]}}, diff};
  assign alpha_x = {{(PW-blfm_pkg::ALPHA_W){1'b0}}, alpha};
  assign prod    = diff_x * alpha_x;
  assign rnd     = prod + 28'sd128;
  assign step    = rnd >>> 8;

  always_comb begin
    unique case (ctrl_i.mode)
      blfm_pkg::FM_PRIME:  smooth_d = avg_i;
      blfm_pkg::FM_UPDATE: smooth_d = smooth_q + step[LW-1:0];
      default:             smooth_d = smooth_q;
    endcase
  end

  assign in_hold  = hold_q < cfg_i.holdoff_items;
  assign hold_d   = (hold_q != blfm_pkg::HOLD_MAX) ? hold_q + 1'b1 : hold_q;
  assign run_inc  = (run_q != blfm_pkg::RUN_MAX) ? run_q + 1'b1 : run_q;
  assign led_link = ctrl_i.link_up ? blfm_pkg::LED_ON : blfm_pkg::LED_OFF;

  always_comb begin
    run_d = run_q;
    low_d = low_q;
    res_d.led_mode = led_link;
    priority if (smooth_d < cfg_i.valid_floor || in_hold) begin
      res_d.led_mode = led_link;
    end else if (low_q) begin
      res_d.led_mode = blfm_pkg::LED_BLINK;
    end else if (smooth_d <= cfg_i.low_threshold) begin
      if (run_inc >= cfg_i.confirm_count) begin
        low_d = 1'b1;
        run_d = '0;
      end else begin
        run_d = run_inc;
      end
    end else begin
      run_d = '0;
    end
    res_d.filtered_level = smooth_d;
    res_d.low_latched    = low_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      hold_q  <= '0;
      run_q   <= '0;
      low_q   <= 1'b0;
    end else begin
      if (ready_o) begin
        valid_q <= valid_i;
      end
      if (fire) begin
        hold_q <= hold_d;
        run_q  <= run_d;
        low_q  <= low_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      smooth_q <= smooth_d;
      res_q    <= res_d;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

`ifndef SYNTHESIS
  a_low_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    low_q |=> low_q)
    else $error("low battery latch was released");

  a_run_idle_when_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    low_q |-> run_q == '0)
    else $error("debounce run still counting after latch");

  a_blink_needs_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && res_q.led_mode == blfm_pkg::LED_BLINK) |-> res_q.low_latched)
    else $error("blink shown without low battery");
`endif

endmodule

// ===== rtl/core/battery_level_filter_monitor.sv =====
// ---------------------------------------------------------------------------
// Battery level filter and monitor
// Slew limits battery samples, averages them over a ring, smooths the
// average and debounces a low battery threshold that drives the LED mode.
//
//   Channel   Dir  Handshake       Word
//   in_if     in   valid/ready     adc_code, link_up
//   out_if    out  valid/ready     filtered_level, low_latched, led_mode
//   cfg       in   cfg_we_i        cfg_idx_i, cfg_wdata_i (no read-back)
//
// One word is taken every cycle while out_if takes results; each accepted
// word passes the input register, ring stage, average stage, and smoother and
// monitor stage with the result register.
// The smoother feedback through the alpha multiply sets the critical path.
// Reset clears all valid flags, the primed flag and the monitor counters.
// A stall on out_if backs up stage by stage; each stage still accepts a
// word while it is empty or the stage after it can take its word.
// ---------------------------------------------------------------------------
module battery_level_filter_monitor #(
  parameter int unsigned RING_DEPTH = blfm_pkg::RING_DEPTH_DEF,
  parameter int unsigned ADC_BITS   = blfm_pkg::ADC_BITS_DEF,
  parameter int unsigned FRAC_BITS  = blfm_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [blfm_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [blfm_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  blfm_in_if.sink                           in_if,
  blfm_out_if.source                        out_if
);

  localparam int unsigned SUM_W = blfm_pkg::LEVEL_W + $clog2(RING_DEPTH);

  blfm_pkg::cfg_t        cfg_q, cfg_d;

  logic                  in_valid_q;
  logic [ADC_BITS-1:0]   in_code_q;
  logic                  in_link_q;

  logic                  flt_ready, flt_valid;
  blfm_pkg::stage_ctrl_t flt_ctrl;
  logic [SUM_W-1:0]      flt_sum;

  logic                  avg_ready, avg_valid;
  blfm_pkg::stage_ctrl_t avg_ctrl;
  logic [blfm_pkg::LEVEL_W-1:0] avg_level;

  logic                  mon_ready;
  blfm_pkg::result_t     mon_res;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (blfm_pkg::cfg_idx_e'(cfg_idx_i))
        blfm_pkg::CFG_SENSE_PRESENT: cfg_d.sense_present = cfg_wdata_i[0];
        blfm_pkg::CFG_GLITCH_STEP:   cfg_d.glitch_step   = cfg_wdata_i;
        blfm_pkg::CFG_SMOOTH_ALPHA:  cfg_d.smooth_alpha  =
                                       cfg_wdata_i[blfm_pkg::ALPHA_W-1:0];
        blfm_pkg::CFG_LOW_THRESHOLD: cfg_d.low_threshold = cfg_wdata_i;
        blfm_pkg::CFG_VALID_FLOOR:   cfg_d.valid_floor   = cfg_wdata_i;
        blfm_pkg::CFG_ABSENT_LEVEL:  cfg_d.absent_level  = cfg_wdata_i;
        blfm_pkg::CFG_CONFIRM_COUNT: cfg_d.confirm_count =
                                       cfg_wdata_i[blfm_pkg::COUNT_W-1:0];
        blfm_pkg::CFG_HOLDOFF_ITEMS: cfg_d.holdoff_items = cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= blfm_pkg::CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign in_if.ready = !in_valid_q || flt_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_if.ready) begin
      in_valid_q <= in_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) begin
      in_code_q <= in_if.adc_code;
      in_link_q <= in_if.link_up;
    end
  end

  blfm_filter #(
    .RING_DEPTH (RING_DEPTH),
    .ADC_BITS   (ADC_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_filter (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .valid_i    (in_valid_q),
    .adc_code_i (in_code_q),
    .link_up_i  (in_link_q),
    .ready_o    (flt_ready),
    .valid_o    (flt_valid),
    .ctrl_o     (flt_ctrl),
    .sum_o      (flt_sum),
    .ready_i    (avg_ready)
  );

  blfm_avg #(
    .RING_DEPTH (RING_DEPTH)
  ) u_avg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (flt_valid),
    .ctrl_i     (flt_ctrl),
    .sum_i      (flt_sum),
    .ready_o    (avg_ready),
    .valid_o    (avg_valid),
    .ctrl_o     (avg_ctrl),
    .avg_o      (avg_level),
    .ready_i    (mon_ready)
  );

  blfm_monitor u_monitor (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .valid_i    (avg_valid),
    .ctrl_i     (avg_ctrl),
    .avg_i      (avg_level),
    .ready_o    (mon_ready),
    .valid_o    (out_if.valid),
    .res_o      (mon_res),
    .ready_i    (out_if.ready)
  );

  assign out_if.filtered_level = mon_res.filtered_level;
  assign out_if.low_latched    = mon_res.low_latched;
  assign out_if.led_mode       = mon_res.led_mode;

endmodule
